>>> rtl/sobel_edge_magnitude_core_defines.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude core - assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst_n is low
`define SEM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobel edge core: same-cycle check failed");

// Next-cycle implication, sampled on clk, ignored while rst_n is low
`define SEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge core: next-cycle check failed");

`endif

>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Widths, reset values and shared types of the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

    // Pixel and register widths
    localparam int PIX_W        = 8;
    localparam int LINE_WIDTH_W = 11;
    localparam int ROW_W        = 2;

    // Line width limits and reset value
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MIN_WIDTH     = 3;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;

    // Row counter saturates once two rows sit in the line stores
    localparam logic [ROW_W-1:0] ROW_FULL = 2'd2;

    // Output saturation level
    localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

    // Left and centre columns of the 3x3 window (top, middle, bottom)
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] tc;
        logic [PIX_W-1:0] mc;
        logic [PIX_W-1:0] bc;
    } window_t;

endpackage

>>> rtl/sobel_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude core
// Streaming 3x3 Sobel |Gx|+|Gy| over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order while out_stall is low;
// each pixel passes the window stage and then the result register, and at
// most one pixel and one result wait inside. Each pixel reads both line
// stores at its column when it is taken, and writes them back in the same
// column as it leaves the window stage; these single-read single-write memories
// set the pipeline depth. frame_start restarts row and column at zero. Once
// two rows are stored and the column is at least two, each pixel gives one
// result, with row_end on the last one of each row. line_width below 3 acts
// as 3 and above MAX_WIDTH as MAX_WIDTH; write it only while the core idles.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sem_pkg::LINE_WIDTH_W-1:0]  cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sem_pkg::PIX_W-1:0]         pixel,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sem_pkg::PIX_W-1:0]         edge_level,
    output logic                              row_end
);

`include "sobel_edge_magnitude_core_defines.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > sem_pkg::LINE_WIDTH_W) ? CW + 1 : sem_pkg::LINE_WIDTH_W;

    // Configuration and position state
    logic [sem_pkg::LINE_WIDTH_W-1:0] line_width_reg;
    logic [CW-1:0]                    col_reg;
    logic [CW-1:0]                    col_next;
    logic [sem_pkg::ROW_W-1:0]        row_reg;
    logic [sem_pkg::ROW_W-1:0]        row_next;

    // Front-end decode of the incoming pixel
    logic [EW-1:0]             lw_ext;
    logic [EW-1:0]             eff_width;
    logic [CW-1:0]             col_cur;
    logic [sem_pkg::ROW_W-1:0] row_cur;
    logic [EW-1:0]             col_inc;
    logic                      last_cur;
    logic                      emit_cur;
    logic                      in_accept;

    // Window stage
    logic                      s1_valid_reg;
    logic [sem_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]             s1_col_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;
    logic                      s1_adv;
    sem_pkg::window_t          win_reg;
    logic [sem_pkg::PIX_W-1:0] top_pix;
    logic [sem_pkg::PIX_W-1:0] mid_pix;
    logic [sem_pkg::PIX_W-1:0] level;

    // Result register
    logic                      out_valid_reg;
    logic [sem_pkg::PIX_W-1:0] edge_level_reg;
    logic                      row_end_reg;

    // Handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // Clamp the line width to the supported range
    always_comb
    begin
        lw_ext = EW'(line_width_reg);
        if (lw_ext < EW'(sem_pkg::MIN_WIDTH))
        begin
            eff_width = EW'(sem_pkg::MIN_WIDTH);
        end
        else if (lw_ext > EW'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = lw_ext;
        end
    end

    // Position of the incoming pixel and of the one after it
    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        col_inc  = EW'(col_cur) + EW'(1);
        last_cur = (col_inc >= eff_width);
        emit_cur = (row_cur >= sem_pkg::ROW_FULL) && (col_cur >= CW'(2));
        col_next = last_cur ? '0 : col_inc[CW-1:0];
        if (last_cur && (row_cur < sem_pkg::ROW_FULL))
        begin
            row_next = row_cur + sem_pkg::ROW_W'(1);
        end
        else
        begin
            row_next = row_cur;
        end
    end

    // Line width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= sem_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            line_width_reg <= cfg_wdata;
        end
    end

    // Advance row and column on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the pixel and its position
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_cur;
            s1_emit_reg  <= emit_cur;
            s1_last_reg  <= last_cur;
        end
    end

    // Upper store takes the middle row, middle store takes the new pixel
    sem_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_upper_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (mid_pix),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (top_pix)
    );

    sem_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_middle_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg),
        .rd_en   (in_accept),
        .rd_addr (col_cur),
        .rd_data (mid_pix)
    );

    // Shift the window by one column
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg.tl <= win_reg.tc;
            win_reg.ml <= win_reg.mc;
            win_reg.bl <= win_reg.bc;
            win_reg.tc <= top_pix;
            win_reg.mc <= mid_pix;
            win_reg.bc <= s1_pixel_reg;
        end
    end

    sem_sobel_kernel u_kernel (
        .win        (win_reg),
        .top        (top_pix),
        .mid        (mid_pix),
        .bot        (s1_pixel_reg),
        .edge_level (level)
    );

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_emit_reg;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            edge_level_reg <= level;
            row_end_reg    <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_level = edge_level_reg;
    assign row_end    = row_end_reg;

    // Checks
    `SEM_ASSERT_NEXT(a_accept_fills_stage, in_accept, s1_valid_reg)
    `SEM_ASSERT_NEXT(a_emit_gives_result, s1_adv && s1_emit_reg, out_valid_reg)
    `SEM_ASSERT_NOW(a_free_result_no_stall, !out_valid_reg, !in_stall)
    `SEM_ASSERT_NOW(a_row_saturates, 1'b1, row_reg <= sem_pkg::ROW_FULL)

endmodule

>>> rtl/sem_line_store.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude line store
// One-write one-read pixel memory with registered read data and a bypass
// for a read that meets a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
module sem_line_store #(
    parameter int DEPTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [sem_pkg::PIX_W-1:0]     wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [sem_pkg::PIX_W-1:0]     rd_data
);

    logic [sem_pkg::PIX_W-1:0] mem [DEPTH];
    logic [sem_pkg::PIX_W-1:0] ram_q_reg;
    logic [sem_pkg::PIX_W-1:0] fwd_reg;
    logic                      hit_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; hold the data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ram_q_reg <= mem[rd_addr];
            fwd_reg   <= wr_data;
        end
    end

    // Note a read that collides with a write in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Forward the colliding write data
    assign rd_data = hit_reg ? fwd_reg : ram_q_reg;

endmodule

>>> rtl/sem_sobel_kernel.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude kernel
// Horizontal and vertical Sobel gradients over one 3x3 window and their
// absolute sum, saturated to the pixel range.
// ----------------------------------------------------------------------------
module sem_sobel_kernel (
    input  sem_pkg::window_t              win,
    input  logic [sem_pkg::PIX_W-1:0]     top,
    input  logic [sem_pkg::PIX_W-1:0]     mid,
    input  logic [sem_pkg::PIX_W-1:0]     bot,
    output logic [sem_pkg::PIX_W-1:0]     edge_level
);

    localparam int SUM_W = sem_pkg::PIX_W + 2;
    localparam int GRAD_W = SUM_W + 1;

    logic [SUM_W-1:0]         right_sum;
    logic [SUM_W-1:0]         left_sum;
    logic [SUM_W-1:0]         bottom_sum;
    logic [SUM_W-1:0]         top_sum;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx_neg;
    logic signed [GRAD_W-1:0] gy_neg;
    logic [SUM_W-1:0]         abs_gx;
    logic [SUM_W-1:0]         abs_gy;
    logic [GRAD_W-1:0]        mag;

    // Weighted column and row sums (weights 1, 2, 1)
    assign right_sum  = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(bot);
    assign left_sum   = SUM_W'(win.tl) + {1'b0, win.ml, 1'b0} + SUM_W'(win.bl);
    assign bottom_sum = SUM_W'(win.bl) + {1'b0, win.bc, 1'b0} + SUM_W'(bot);
    assign top_sum    = SUM_W'(win.tl) + {1'b0, win.tc, 1'b0} + SUM_W'(top);

    // Signed gradients
    assign gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});
    assign gx_neg = -gx;
    assign gy_neg = -gy;

    // Magnitudes; both fit the unsigned sum width
    assign abs_gx = gx[GRAD_W-1] ? gx_neg[SUM_W-1:0] : gx[SUM_W-1:0];
    assign abs_gy = gy[GRAD_W-1] ? gy_neg[SUM_W-1:0] : gy[SUM_W-1:0];
    assign mag    = {1'b0, abs_gx} + {1'b0, abs_gy};

    // Saturate to the pixel range
    assign edge_level = (mag > GRAD_W'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX
                                                           : mag[sem_pkg::PIX_W-1:0];

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude core - self-checking testbench
// Streams grey pixels into the core under random source gaps and sink stalls.
// A local model of the line stores and the 3x3 window predicts every edge
// result, and each result is checked field by field as it leaves the core.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = sem_pkg::MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 4;
    localparam int RANDOM_ITEMS = 60;
    localparam int CALM_ITEMS   = 30;

    // Pixel content styles for generated frames
    typedef enum int { FILL_RANDOM, FILL_EXTREME, FILL_SMOOTH } fill_mode_t;

    // Random stream shapes
    typedef enum int { SHAPE_FRAME, SHAPE_TRUNCATED, SHAPE_CONTINUE, SHAPE_SHRINK } shape_t;

    typedef struct packed {
        logic [sem_pkg::PIX_W-1:0] level;
        logic                      last;
    } edge_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_we      = 1'b0;
    logic [sem_pkg::LINE_WIDTH_W-1:0] cfg_wdata   = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_stall;
    logic [sem_pkg::PIX_W-1:0]        pixel       = '0;
    logic                             frame_start = 1'b0;
    logic                             out_valid;
    logic                             out_stall   = 1'b0;
    logic [sem_pkg::PIX_W-1:0]        edge_level;
    logic                             row_end;

    // Model state: line stores, window, position and register copy
    logic [sem_pkg::PIX_W-1:0]        upper_line  [MAX_W];
    logic [sem_pkg::PIX_W-1:0]        middle_line [MAX_W];
    sem_pkg::window_t                 nbhd;
    int unsigned                      col_pos;
    logic [sem_pkg::ROW_W-1:0]        row_pos;
    logic [sem_pkg::LINE_WIDTH_W-1:0] width_reg;

    edge_t                   pending_edges[$];
    int                      error_count  = 0;
    int unsigned             cycle_count  = 0;
    int                      pixels_sent  = 0;
    bit                      feed_gaps    = 1'b0;
    bit                      sink_stalls  = 1'b0;
    int                      stall_left   = 0;

    sobel_edge_magnitude_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .edge_level  (edge_level),
        .row_end     (row_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp the programmed width to the range the core supports
    function automatic int unsigned active_width(input logic [sem_pkg::LINE_WIDTH_W-1:0] w);
        if (w < sem_pkg::MIN_WIDTH)
        begin
            return sem_pkg::MIN_WIDTH;
        end
        if (w > MAX_W)
        begin
            return MAX_W;
        end
        return 32'(w);
    endfunction

    // Advance the model by one pixel and queue the edge result it gives
    function automatic void predict_edge(input logic [sem_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned               w;
        int unsigned               c;
        logic [sem_pkg::PIX_W-1:0] top;
        logic [sem_pkg::PIX_W-1:0] mid;
        bit                        last;
        int                        gx;
        int                        gy;
        int                        mag;
        edge_t                     res;

        w = active_width(width_reg);
        if (fs)
        begin
            col_pos = 0;
            row_pos = '0;
        end
        c    = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        last = (c + 1 >= w);
        top  = upper_line[c];
        mid  = middle_line[c];

        if (row_pos >= sem_pkg::ROW_FULL && c >= 2)
        begin
            gx = (int'(top) + 2 * int'(mid) + int'(pix))
               - (int'(nbhd.tl) + 2 * int'(nbhd.ml) + int'(nbhd.bl));
            gy = (int'(nbhd.bl) + 2 * int'(nbhd.bc) + int'(pix))
               - (int'(nbhd.tl) + 2 * int'(nbhd.tc) + int'(top));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > int'(sem_pkg::EDGE_MAX))
            begin
                mag = int'(sem_pkg::EDGE_MAX);
            end
            res.level = mag[sem_pkg::PIX_W-1:0];
            res.last  = last;
            pending_edges.push_back(res);
        end

        // Shift the window left and store the new column
        nbhd.tl = nbhd.tc;
        nbhd.ml = nbhd.mc;
        nbhd.bl = nbhd.bc;
        nbhd.tc = top;
        nbhd.mc = mid;
        nbhd.bc = pix;
        upper_line[c]  = mid;
        middle_line[c] = pix;

        if (last)
        begin
            col_pos = 0;
            if (row_pos < sem_pkg::ROW_FULL)
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    function automatic logic [sem_pkg::PIX_W-1:0] draw_pixel(input fill_mode_t mode);
        case (mode)
            FILL_EXTREME: return $urandom_range(0, 1) ? {sem_pkg::PIX_W{1'b1}} : '0;
            FILL_SMOOTH:  return sem_pkg::PIX_W'($urandom_range(100, 131));
            default:      return sem_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel request, with an optional gap first, and hold it until taken
    task automatic push_pixel(input logic [sem_pkg::PIX_W-1:0] pix, input logic fs);
        if (feed_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= pix;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_edge(pix, fs);
        pixels_sent++;
    endtask

    task automatic send_run(input int count, input fill_mode_t mode);
        repeat (count) push_pixel(draw_pixel(mode), 1'b0);
    endtask

    // Start a frame and send whole rows at the current width plus a few extra pixels
    task automatic send_frame(input int rows, input int extra, input fill_mode_t mode);
        int total;

        total = rows * int'(active_width(width_reg)) + extra;
        if (total < 1)
        begin
            total = 1;
        end
        push_pixel(draw_pixel(mode), 1'b1);
        send_run(total - 1, mode);
    endtask

    // Drop valid and wait until every queued result has left the core
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_line_width(input logic [sem_pkg::LINE_WIDTH_W-1:0] w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg  = w;
    endtask

    // Reset width, with pixels flowing before any frame start
    task automatic test_reset_width();
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        send_run(2 * int'(active_width(width_reg)) + 4, FILL_RANDOM);
    endtask

    // Hand-built frames at the narrowest width: flat, step and saturating edges
    task automatic test_directed();
        logic [sem_pkg::PIX_W-1:0] steps [24] = '{
            8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
            8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,
            8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,
            8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255
        };

        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        write_line_width(11'd3);
        for (int i = 0; i < 24; i++)
        begin
            push_pixel(steps[i], (i == 0 || i == 12));
        end
    endtask

    // Widths below the minimum
    task automatic test_width_limits();
        logic [sem_pkg::LINE_WIDTH_W-1:0] narrow [3] = '{11'd0, 11'd1, 11'd2};

        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        foreach (narrow[i])
        begin
            write_line_width(narrow[i]);
            send_frame(3, 0, FILL_RANDOM);
        end
    endtask

    // Frame start arriving mid-row and mid-frame
    task automatic test_frame_restart();
        feed_gaps   = 1'b1;
        sink_stalls = 1'b0;
        write_line_width(11'd6);
        send_frame(3, 3, FILL_RANDOM);
        send_frame(1, 2, FILL_SMOOTH);
        send_frame(4, 0, FILL_RANDOM);
    endtask

    // Shrink the width while a row is under way
    task automatic test_width_shrink();
        feed_gaps   = 1'b0;
        sink_stalls = 1'b1;
        write_line_width(11'd8);
        send_frame(3, 6, FILL_RANDOM);
        write_line_width(11'd4);
        send_run(11, FILL_RANDOM);
        write_line_width(11'd0);
        send_run(9, FILL_SMOOTH);
        write_line_width(11'd10);
        send_frame(3, 7, FILL_RANDOM);
        write_line_width(11'd7);
        send_run(14, FILL_RANDOM);
    endtask

    // Mostly well-formed frames with random content, plus broken streams
    task automatic test_random_stream();
        int                               start;
        int unsigned                      cur_w;
        logic [sem_pkg::LINE_WIDTH_W-1:0] new_w;
        bit                               grew;
        shape_t                           shape;
        fill_mode_t                       mode;
        int                               pick;

        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS)
        begin
            feed_gaps   = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);
            mode        = fill_mode_t'($urandom_range(0, 2));
            pick        = $urandom_range(0, 9);
            shape       = (pick == 0) ? SHAPE_TRUNCATED :
                          (pick == 1) ? SHAPE_CONTINUE  :
                          (pick == 2) ? SHAPE_SHRINK    : SHAPE_FRAME;
            grew        = 1'b0;

            if ($urandom_range(0, 2) == 0)
            begin
                pick  = $urandom_range(0, 9);
                new_w = sem_pkg::LINE_WIDTH_W'((pick == 0) ? $urandom_range(0, 2)   :
                                               (pick == 1) ? $urandom_range(17, 80) :
                                                             $urandom_range(3, 16));
                grew  = active_width(new_w) > active_width(width_reg);
                write_line_width(new_w);
            end

            // A wider line leaves store columns unwritten until a new frame fills them
            if (grew && (shape == SHAPE_CONTINUE || shape == SHAPE_SHRINK))
            begin
                shape = SHAPE_FRAME;
            end
            if (shape == SHAPE_SHRINK && col_pos == 0)
            begin
                shape = SHAPE_CONTINUE;
            end

            cur_w = active_width(width_reg);
            case (shape)
                SHAPE_TRUNCATED:
                begin
                    send_frame($urandom_range(0, 2), $urandom_range(0, cur_w - 1), mode);
                end
                SHAPE_CONTINUE:
                begin
                    send_run($urandom_range(1, 3 * cur_w), mode);
                end
                SHAPE_SHRINK:
                begin
                    write_line_width(sem_pkg::LINE_WIDTH_W'($urandom_range(0, col_pos)));
                    send_run($urandom_range(1, 2 * int'(active_width(width_reg))), mode);
                end
                default:
                begin
                    send_frame($urandom_range(3, 6), 0, mode);
                end
            endcase

            // Hold the source back until the core has delivered everything
            if ($urandom_range(0, 3) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // Closing stretch at full rate with no gaps or stalls
    task automatic test_full_rate();
        int start;

        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        write_line_width(sem_pkg::LINE_WIDTH_W'($urandom_range(3, 16)));
        start = pixels_sent;
        while (pixels_sent - start < CALM_ITEMS)
        begin
            send_frame($urandom_range(3, 5), 0, fill_mode_t'($urandom_range(0, 2)));
        end
    endtask

    // Sink stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 15);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        edge_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_edges.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got edge_level=%0d row_end=%0b",
                         $time, edge_level, row_end);
                error_count++;
            end
            else
            begin
                want = pending_edges.pop_front();
                if (edge_level !== want.level)
                begin
                    $display("%0t: edge_level mismatch, expected %0d, got %0d",
                             $time, want.level, edge_level);
                    error_count++;
                end
                if (row_end !== want.last)
                begin
                    $display("%0t: row_end mismatch, expected %0b, got %0b",
                             $time, want.last, row_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        nbhd      = '0;
        col_pos   = 0;
        row_pos   = '0;
        width_reg = sem_pkg::LINE_WIDTH_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_width();
        test_directed();
        test_width_limits();
        test_frame_restart();
        test_width_shrink();
        test_random_stream();
        test_full_rate();

        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_line_store.sv
rtl/sem_sobel_kernel.sv
rtl/sobel_edge_magnitude_core.sv
tb/sv/testbench.sv
